// ----- hw/rtl/crc8cfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package crc8cfr_pkg;

	// frame layout: two little-endian words, then the check byte
	localparam int PAYLOAD_BYTES    = 8;
	localparam int BUFFER_BYTES_DEF = 16;
	localparam int POS_W            = $clog2(PAYLOAD_BYTES);
	localparam int COUNT_W          = 5;
	localparam int ERR_W            = 4;
	localparam int IN_TDATA_W       = 8;
	localparam int IN_TUSER_W       = 1 + ERR_W;
	localparam int OUT_TDATA_W      = 72;
	localparam int OUT_TUSER_W      = 1 + ERR_W;
	localparam int OUT_PAD_W        = OUT_TDATA_W - 64 - COUNT_W;

	// reflected CRC-8, LSB first
	localparam logic [7:0] CRC_POLY = 8'h8C;
	localparam logic [7:0] CRC_INIT = 8'h00;

	// error flag positions
	localparam int ERR_PARITY  = 0;
	localparam int ERR_FRAMING = 1;
	localparam int ERR_NOISE   = 2;
	localparam int ERR_OVERRUN = 3;

	typedef struct packed {
		logic [ERR_W-1:0] errors;
		logic             line_idle;
		logic [7:0]       data_byte;
		logic             byte_valid;
	} beat_t;

	typedef struct packed {
		logic [COUNT_W-1:0] bytes_received;
		logic [ERR_W-1:0]   errors_seen;
		logic [31:0]        second_word;
		logic [31:0]        first_word;
		logic               check_ok;
	} result_t;

	// [position][data bit] -> CRC contribution at the end of the payload
	typedef logic [PAYLOAD_BYTES-1:0][7:0][7:0] crc_tbl_t;

	// shift the register over n zero data bits
	function automatic logic [7:0] crc_zero_bits(input logic [7:0] c, input int n);
		logic [7:0] r;
		r = c;
		for (int k = 0; k < n; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	// CRC is linear: each payload bit adds a fixed pattern to the final value
	function automatic crc_tbl_t crc_table();
		crc_tbl_t   t;
		logic [7:0] e;
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			for (int j = 0; j < 8; j++) begin
				e       = '0;
				e[j]    = 1'b1;
				t[i][j] = crc_zero_bits(e, 8 * (PAYLOAD_BYTES - i));
			end
		end
		return t;
	endfunction

	localparam crc_tbl_t   CRC_TABLE     = crc_table();
	localparam logic [7:0] CRC_INIT_TERM = crc_zero_bits(CRC_INIT, 8 * PAYLOAD_BYTES);

endpackage

`default_nettype wire

// ----- hw/rtl/crc8_checked_frame_receiver_core.sv -----
// Path: an accepted beat waits in the input register; when a line-idle beat advances, its
// frame result is loaded into the result register, which holds it on m_axis until taken.
// Throughput: one input beat per cycle; a line-idle beat waits in the input
// register only while the previous result is still held on m_axis.
// Reset: arst_n clears, asynchronously, the frame store, flags, count and all valids.
`timescale 1ns / 1ps
`default_nettype none

module crc8_checked_frame_receiver_core #(
	parameter int BUFFER_BYTES = crc8cfr_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// data_byte[7:0]
	input  wire logic [crc8cfr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// byte_valid[0], parity_error[1], framing_error[2], noise_error[3], overrun_error[4]
	input  wire logic [crc8cfr_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
	// line_idle: end of frame
	input  wire logic                                 s_axis_tlast,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// first_word[31:0], second_word[63:32], bytes_received[68:64], zero[71:69]
	output logic [crc8cfr_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	// check_ok[0], parity_seen[1], framing_seen[2], noise_seen[3], overrun_seen[4]
	output logic [crc8cfr_pkg::OUT_TUSER_W-1:0]       m_axis_tuser
);
	import crc8cfr_pkg::*;

	beat_t   s_beat;
	beat_t   beat_s1;
	logic    valid_s1;
	logic    advance;
	logic    emit;
	logic    out_free;
	result_t frame_result;
	result_t result_q;

	// unpack the incoming beat
	always_comb begin
		s_beat.byte_valid = s_axis_tuser[0];
		s_beat.data_byte  = s_axis_tdata;
		s_beat.line_idle  = s_axis_tlast;
		s_beat.errors     = s_axis_tuser[IN_TUSER_W-1:1];
	end

	// Non-idle beats only touch the frame state, so they move on even while
	// a result waits on m_axis; an idle beat needs the output register free.
	assign advance = valid_s1 && (!beat_s1.line_idle || out_free);
	assign emit    = advance && beat_s1.line_idle;

	crc8cfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_valid  (s_axis_tvalid),
		.s_ready  (s_axis_tready),
		.s_beat   (s_beat),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	// byte store, sticky flags, count and running CRC; result built from
	// the state including the current beat
	crc8cfr_frame #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.beat    (beat_s1),
		.result  (frame_result)
	);

	crc8cfr_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (emit),
		.d        (frame_result),
		.m_ready  (m_axis_tready),
		.m_valid  (m_axis_tvalid),
		.result_q (result_q),
		.free     (out_free)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, result_q.bytes_received,
	                       result_q.second_word, result_q.first_word};
	assign m_axis_tuser = {result_q.errors_seen, result_q.check_ok};

endmodule

`default_nettype wire

// ----- hw/rtl/crc8cfr_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module crc8cfr_in_stage (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_valid,
	output logic                     s_ready,
	input  wire crc8cfr_pkg::beat_t  s_beat,
	input  wire logic                advance,
	output logic                     valid_s1,
	output crc8cfr_pkg::beat_t       beat_s1
);
	import crc8cfr_pkg::*;

	logic take;

	assign s_ready = !valid_s1 || advance;
	assign take    = s_valid && s_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			beat_s1 <= s_beat;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/crc8cfr_frame.sv -----
`timescale 1ns / 1ps
`default_nettype none

module crc8cfr_frame #(
	parameter int BUFFER_BYTES = crc8cfr_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire crc8cfr_pkg::beat_t  beat,
	output crc8cfr_pkg::result_t     result
);
	import crc8cfr_pkg::*;

	localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

	logic [7:0]       payload_q [PAYLOAD_BYTES];
	logic [7:0]       check_q;
	logic [7:0]       acc_q;
	logic [CNT_W-1:0] idx_q;
	logic [ERR_W-1:0] sticky_q;

	logic [7:0]       payload_next [PAYLOAD_BYTES];
	logic [7:0]       check_next;
	logic [7:0]       acc_next;
	logic [7:0]       contrib;
	logic [CNT_W-1:0] idx_next;
	logic [ERR_W-1:0] sticky_next;
	logic [POS_W-1:0] pos;
	logic             store;
	logic             in_payload;

	always_comb begin
		store      = beat.byte_valid && (idx_q < CNT_W'(BUFFER_BYTES));
		in_payload = store && (idx_q < CNT_W'(PAYLOAD_BYTES));
		pos        = idx_q[POS_W-1:0];

		contrib = '0;
		for (int j = 0; j < 8; j++) begin
			if (beat.data_byte[j]) begin
				contrib = contrib ^ CRC_TABLE[pos][j];
			end
		end

		payload_next = payload_q;
		if (in_payload) begin
			payload_next[pos] = beat.data_byte;
		end

		check_next  = (store && idx_q == CNT_W'(PAYLOAD_BYTES)) ? beat.data_byte : check_q;
		acc_next    = in_payload ? (acc_q ^ contrib) : acc_q;
		idx_next    = store ? (idx_q + CNT_W'(1)) : idx_q;
		sticky_next = sticky_q | beat.errors;
	end

	// missing bytes are zero and add nothing to the CRC
	always_comb begin
		result.check_ok       = (acc_next == check_next);
		result.first_word     = {payload_next[3], payload_next[2],
		                         payload_next[1], payload_next[0]};
		result.second_word    = {payload_next[7], payload_next[6],
		                         payload_next[5], payload_next[4]};
		result.errors_seen    = sticky_next;
		result.bytes_received = COUNT_W'(idx_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAYLOAD_BYTES; i++) begin
				payload_q[i] <= '0;
			end
			check_q  <= '0;
			acc_q    <= CRC_INIT_TERM;
			idx_q    <= '0;
			sticky_q <= '0;
		end else if (advance) begin
			if (beat.line_idle) begin
				for (int i = 0; i < PAYLOAD_BYTES; i++) begin
					payload_q[i] <= '0;
				end
				check_q  <= '0;
				acc_q    <= CRC_INIT_TERM;
				idx_q    <= '0;
				sticky_q <= '0;
			end else begin
				payload_q <= payload_next;
				check_q   <= check_next;
				acc_q     <= acc_next;
				idx_q     <= idx_next;
				sticky_q  <= sticky_next;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/crc8cfr_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module crc8cfr_out_stage (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire crc8cfr_pkg::result_t  d,
	input  wire logic                  m_ready,
	output logic                       m_valid,
	output crc8cfr_pkg::result_t       result_q,
	output logic                       free
);
	import crc8cfr_pkg::*;

	assign free = !m_valid || m_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid <= 1'b0;
		end else if (load) begin
			m_valid <= 1'b1;
		end else if (m_ready) begin
			m_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/crc8cfr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module crc8cfr_checker #(
	parameter int BUFFER_BYTES = crc8cfr_pkg::BUFFER_BYTES_DEF
) (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               m_axis_tvalid,
	input wire logic                               m_axis_tready,
	input wire logic [crc8cfr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic [crc8cfr_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
	import crc8cfr_pkg::*;

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// count saturates at the buffer size, pad bits stay zero
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		(m_axis_tdata[OUT_TDATA_W-1:64+COUNT_W] == '0) &&
		((BUFFER_BYTES >= 32) || (m_axis_tdata[68:64] <= 5'(BUFFER_BYTES))))
		else $error("byte count out of range");

	// empty frame: zero payload checks against a zero check byte
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[68:64] == '0) && (BUFFER_BYTES < 32) |->
		(m_axis_tdata[63:0] == '0) && m_axis_tuser[0])
		else $error("empty frame gave nonzero payload or failed check");

	// short frame: bytes 4..7 never arrived
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[68:64] < 5'd5) && (BUFFER_BYTES < 32) |->
		(m_axis_tdata[63:32] == '0))
		else $error("second word not cleared on short frame");

endmodule

bind crc8_checked_frame_receiver_core crc8cfr_checker #(
	.BUFFER_BYTES (BUFFER_BYTES)
) u_crc8cfr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- bench/tb_crc8_checked_frame_receiver_core.sv -----
`timescale 1ns / 1ps

module tb_crc8_checked_frame_receiver_core;
	import crc8cfr_pkg::*;

	localparam int FRAME_BUFFER = BUFFER_BYTES_DEF;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 120;

	// Tracks the frame being received and holds the verdicts still owed by the block.
	class crc_frame_tracker;
		logic [PAYLOAD_BYTES-1:0][7:0] payload;
		logic [7:0]                    check_byte;
		int                            fill;
		logic [ERR_W-1:0]              sticky;
		result_t                       awaited[$];
		int                            mismatches;
		int                            frames_checked;

		function new();
			clear_frame();
			mismatches     = 0;
			frames_checked = 0;
		endfunction

		function void clear_frame();
			payload    = '0;
			check_byte = '0;
			fill       = 0;
			sticky     = '0;
		endfunction

		// reflected CRC-8, LSB first, over the payload bytes in arrival order
		static function logic [7:0] crc_of(logic [PAYLOAD_BYTES-1:0][7:0] bytes);
			logic [7:0] crc;
			logic [7:0] d;
			crc = CRC_INIT;
			for (int i = 0; i < PAYLOAD_BYTES; i++) begin
				d = bytes[i];
				for (int k = 0; k < 8; k++) begin
					crc = (crc[0] ^ d[0]) ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
					d   = d >> 1;
				end
			end
			return crc;
		endfunction

		function void absorb_beat(beat_t b);
			result_t r;
			sticky |= b.errors;
			if (b.byte_valid && fill < FRAME_BUFFER) begin
				if (fill < PAYLOAD_BYTES)
					payload[fill] = b.data_byte;
				else if (fill == PAYLOAD_BYTES)
					check_byte = b.data_byte;
				fill++;
			end
			if (b.line_idle) begin
				r.check_ok       = (crc_of(payload) == check_byte);
				r.first_word     = payload[3:0];
				r.second_word    = payload[7:4];
				r.errors_seen    = sticky;
				r.bytes_received = COUNT_W'(fill);
				awaited.push_back(r);
				clear_frame();
			end
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction

		task report(input string note);
			mismatches++;
			$display("[%0t] frame %0d: %s", $realtime, frames_checked, note);
		endtask

		task check_field(input string what, input logic [31:0] got, input logic [31:0] want);
			if (got !== want)
				report($sformatf("%s got %h want %h", what, got, want));
		endtask

		task compare_frame(input logic [OUT_TDATA_W-1:0] tdata,
				input logic [OUT_TUSER_W-1:0] tuser);
			result_t want;
			if (awaited.size() == 0) begin
				report("result with no frame pending");
				return;
			end
			want = awaited.pop_front();
			check_field("check_ok", tuser[0], want.check_ok);
			check_field("first_word", tdata[31:0], want.first_word);
			check_field("second_word", tdata[63:32], want.second_word);
			check_field("parity_seen", tuser[1+ERR_PARITY], want.errors_seen[ERR_PARITY]);
			check_field("framing_seen", tuser[1+ERR_FRAMING], want.errors_seen[ERR_FRAMING]);
			check_field("noise_seen", tuser[1+ERR_NOISE], want.errors_seen[ERR_NOISE]);
			check_field("overrun_seen", tuser[1+ERR_OVERRUN], want.errors_seen[ERR_OVERRUN]);
			check_field("bytes_received", tdata[64 +: COUNT_W], want.bytes_received);
			check_field("pad bits", tdata[OUT_TDATA_W-1 -: OUT_PAD_W], '0);
			frames_checked++;
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;

	crc_frame_tracker tracker = new();

	int send_idle_pct = 0;   // chance per cycle that the sender holds back
	int stall_pct     = 0;   // chance per cycle that the receiver stalls
	int hold_request  = 0;   // long receiver hold, picked up by the ready process
	int hold_left     = 0;
	int items_sent    = 0;
	int cycles        = 0;

	crc8_checked_frame_receiver_core #(
		.BUFFER_BYTES(FRAME_BUFFER)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver side: random stalls, plus a long hold when requested
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// result beats, sampled at the edge that accepts them
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.compare_frame(m_axis_tdata, m_axis_tuser);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [ERR_W-1:0] pick_errors(input int pct);
		logic [ERR_W-1:0] e;
		for (int k = 0; k < ERR_W; k++)
			e[k] = ($urandom_range(99) < pct);
		return e;
	endfunction

	function automatic logic [7:0] payload_crc(input logic [7:0] bytes[$]);
		logic [PAYLOAD_BYTES-1:0][7:0] body;
		for (int i = 0; i < PAYLOAD_BYTES; i++)
			body[i] = bytes[i];
		return crc_frame_tracker::crc_of(body);
	endfunction

	// Offer one beat after a random gap; returns right after the accepting edge.
	task automatic send_beat(input beat_t b);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b.data_byte;
		s_axis_tuser  <= {b.errors, b.byte_valid};
		s_axis_tlast  <= b.line_idle;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		tracker.absorb_beat(b);
		if (b.byte_valid || b.line_idle || b.errors != '0)
			items_sent++;
	endtask

	// One frame: byte beats, maybe blank beats in between, closed by a line-idle mark
	// either on the last byte or on a beat of its own.
	task automatic send_frame(input logic [7:0] bytes[$], input bit idle_on_byte,
			input int err_pct, input int blank_pct);
		beat_t b;
		for (int i = 0; i < bytes.size(); i++) begin
			if ($urandom_range(99) < blank_pct) begin
				b           = '0;
				b.data_byte = $urandom_range(255);
				b.errors    = pick_errors(err_pct);
				send_beat(b);
			end
			b.byte_valid = 1'b1;
			b.data_byte  = bytes[i];
			b.errors     = pick_errors(err_pct);
			b.line_idle  = idle_on_byte && (i == bytes.size() - 1);
			send_beat(b);
		end
		if (!idle_on_byte || bytes.size() == 0) begin
			b.byte_valid = 1'b0;
			b.data_byte  = $urandom_range(255);
			b.errors     = pick_errors(err_pct);
			b.line_idle  = 1'b1;
			send_beat(b);
		end
	endtask

	// Mostly well-formed frames with a valid check byte; the rest short, long
	// or overflowing the buffer.
	task automatic random_frame(input int max_len);
		logic [7:0] bytes[$];
		int         kind;
		int         n;
		kind = $urandom_range(99);
		if (kind < 70)
			n = PAYLOAD_BYTES + 1;
		else if (kind < 85)
			n = $urandom_range(PAYLOAD_BYTES);
		else
			n = $urandom_range(max_len, PAYLOAD_BYTES + 1);
		for (int i = 0; i < n; i++)
			bytes.push_back($urandom_range(255));
		if (kind < 70 && n > PAYLOAD_BYTES) begin
			bytes[PAYLOAD_BYTES] = payload_crc(bytes);
			if ($urandom_range(9) == 0)
				bytes[PAYLOAD_BYTES] ^= 8'(1 << $urandom_range(7));
		end
		send_frame(bytes, $urandom_range(1), 8, 10);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		beat_t      b;
		logic [7:0] bytes[$];
		int         target;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty frame: all bytes read as zero, so the check passes
		b           = '0;
		b.line_idle = 1'b1;
		send_beat(b);

		// byte and every error flag on the idle beat itself
		b.byte_valid = 1'b1;
		b.data_byte  = 8'hFF;
		b.errors     = '1;
		send_beat(b);

		// all-ones payload with its correct check byte, idle on the check byte
		for (int i = 0; i < PAYLOAD_BYTES; i++)
			bytes.push_back(8'hFF);
		bytes.push_back(payload_crc(bytes));
		send_frame(bytes, 1'b1, 0, 0);

		// all-zero payload with a wrong check byte, idle on its own beat
		bytes = {};
		for (int i = 0; i < PAYLOAD_BYTES; i++)
			bytes.push_back(8'h00);
		bytes.push_back(8'hFF);
		send_frame(bytes, 1'b0, 0, 0);

		// data without byte_valid is ignored; short frame after it
		b           = '0;
		b.data_byte = 8'hA5;
		send_beat(b);
		bytes = {8'h12, 8'h34};
		send_frame(bytes, 1'b0, 0, 0);
		drain_results();

		// random phases: none, sender gaps, receiver stalls, both
		target = items_sent;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 72; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 72; end
				default: begin send_idle_pct = 18; stall_pct = 18; end
			endcase
			target += PHASE_ITEMS;
			while (items_sent < target)
				random_frame(FRAME_BUFFER + 4);

			// long receiver hold while short frames keep coming: input must back up
			if (phase == 1) begin
				send_idle_pct = 0;
				stall_pct     = 0;
				hold_request  = 300;
				for (int i = 0; i < 8; i++)
					random_frame(PAYLOAD_BYTES + 1);
			end

			// sender waits until every verdict is back
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
